/* hw/rtl/lookq_pkg.sv */
`timescale 1ns / 1ps

package lookq_pkg;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 4;

    // 1.0 in Q1.30.
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;

    // Quaternion component slots.
    localparam logic [1:0] QI_X = 2'd0;
    localparam logic [1:0] QI_Y = 2'd1;
    localparam logic [1:0] QI_Z = 2'd2;
    localparam logic [1:0] QI_W = 2'd3;

    // One classified word as it travels from front to back.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic               zero;   // eye equals target
        logic               vert;   // forward is vertical
    } t_item;

endpackage

/* hw/rtl/lookq_front.sv */
`timescale 1ns / 1ps

module lookq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic signed [31:0]  i_eye_x,
    input  logic signed [31:0]  i_eye_y,
    input  logic signed [31:0]  i_eye_z,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    input  logic signed [31:0]  i_target_z,
    output logic                o_push,
    output lookq_pkg::t_item    o_item
);

    logic             r_v;
    lookq_pkg::t_item r_item;
    logic signed [32:0] w_dx, w_dy, w_dz;

    assign w_dx = 33'(i_target_x) - 33'(i_eye_x);
    assign w_dy = 33'(i_target_y) - 33'(i_eye_y);
    assign w_dz = 33'(i_target_z) - 33'(i_eye_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_accept;
        end
    end

    // Classify exact-zero cases on the raw differences.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item.dx   <= w_dx;
            r_item.dy   <= w_dy;
            r_item.dz   <= w_dz;
            r_item.zero <= (w_dx == '0) && (w_dy == '0) && (w_dz == '0);
            r_item.vert <= (w_dx == '0) && (w_dy == '0);
        end
    end

    assign o_push = r_v;
    assign o_item = r_item;

endmodule

/* hw/rtl/lookq_queue.sv */
`timescale 1ns / 1ps

module lookq_queue #(
    parameter int DEPTH = lookq_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  lookq_pkg::t_item             i_item,
    input  logic                         i_pop,
    output logic                         o_avail,
    output lookq_pkg::t_item             o_head,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lookq_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

/* hw/rtl/lookq_back.sv */
`timescale 1ns / 1ps

module lookq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  lookq_pkg::t_item    i_item,
    output logic                o_take,
    output logic                o_valid,
    output logic signed [31:0]  o_quat_x,
    output logic signed [31:0]  o_quat_y,
    output logic signed [31:0]  o_quat_z,
    output logic signed [31:0]  o_quat_w
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NSET = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_RT   = 4'd3;
    localparam logic [3:0] S_DVI  = 4'd4;
    localparam logic [3:0] S_DV   = 4'd5;
    localparam logic [3:0] S_DVF  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_TR   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [1:0] P_F   = 2'd0;
    localparam logic [1:0] P_C   = 2'd1;
    localparam logic [1:0] P_PIV = 2'd2;
    localparam logic [1:0] P_Q   = 2'd3;

    localparam logic [63:0] SQ_BIT0 = 64'h4000_0000_0000_0000;

    function automatic logic [32:0] abs33(input logic signed [32:0] d);
        abs33 = d[32] ? 33'(-d) : 33'(d);
    endfunction

    function automatic logic [29:0] shn(input logic [32:0] a, input logic left,
                                        input logic [5:0] sh);
        logic [63:0] w;
        w = left ? ({31'b0, a} << sh) : ({31'b0, a} >> sh);
        shn = w[29:0];
    endfunction

    function automatic logic signed [33:0] rnd_q30(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] t;
        mag = p[63] ? 64'(-p) : 64'(p);
        t   = (mag + 64'd536870912) >> 30;
        rnd_q30 = p[63] ? -$signed(t[33:0]) : $signed(t[33:0]);
    endfunction

    function automatic logic [1:0] qdest(input logic [1:0] br, input logic [1:0] idx);
        logic [1:0] d;
        d = lookq_pkg::QI_W;
        case (br)
            2'd0: d = (idx == 2'd0) ? lookq_pkg::QI_X :
                      (idx == 2'd1) ? lookq_pkg::QI_Y : lookq_pkg::QI_Z;
            2'd1: d = (idx == 2'd0) ? lookq_pkg::QI_W :
                      (idx == 2'd1) ? lookq_pkg::QI_Y : lookq_pkg::QI_Z;
            2'd2: d = (idx == 2'd0) ? lookq_pkg::QI_W :
                      (idx == 2'd1) ? lookq_pkg::QI_X : lookq_pkg::QI_Z;
            default: d = (idx == 2'd0) ? lookq_pkg::QI_W :
                         (idx == 2'd1) ? lookq_pkg::QI_X : lookq_pkg::QI_Y;
        endcase
        qdest = d;
    endfunction

    logic [3:0]  r_state;
    logic [1:0]  r_phase;
    logic [4:0]  r_cnt;
    logic [1:0]  r_idx;
    logic [1:0]  r_br;
    logic        r_vert, r_n3;
    logic signed [32:0] r_d [3];
    logic [29:0] r_mag [3];
    logic [63:0] r_acc;
    logic [63:0] r_sv, r_sres, r_sbit;
    logic [63:0] r_rem, r_dsh;
    logic [31:0] r_q;
    logic        r_sat, r_neg;
    logic signed [31:0] r_f [3];
    logic signed [31:0] r_c [2];
    logic signed [33:0] r_r [3];
    logic signed [33:0] r_u [3];
    logic signed [63:0] r_prod;
    logic [30:0] r_piv;
    logic signed [31:0] r_quat [4];

    // normalization setup
    logic [32:0] w_a0, w_a1, w_a2, w_mx;
    logic [5:0]  w_msb, w_sh;
    logic        w_left;
    // sum of squares
    logic [59:0] w_sq;
    logic [63:0] w_sum;
    // root step
    logic [63:0] w_st, n_sv, n_sres;
    logic [63:0] w_ph;
    logic [30:0] w_piv;
    // matrix
    logic signed [33:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [35:0] w_tr, w_v;
    logic [1:0]  w_br;
    logic signed [34:0] w_num;
    logic [34:0] w_nabs;
    // divider
    logic [63:0] w_dn;
    logic [32:0] w_den;
    logic        w_dneg, w_dzero;
    logic        w_ge;
    logic [31:0] w_qm;
    logic signed [31:0] w_val;
    logic        w_last;
    // multiplier
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_mul;

    always_comb begin
        w_a0 = abs33(r_d[0]);
        w_a1 = abs33(r_d[1]);
        w_a2 = r_n3 ? abs33(r_d[2]) : '0;
        w_mx = w_a0;
        if (w_a1 > w_mx) w_mx = w_a1;
        if (w_a2 > w_mx) w_mx = w_a2;
        w_msb = '0;
        for (int i = 0; i < 33; i++) begin
            if (w_mx[i]) w_msb = 6'(i);
        end
        w_left = (w_mx < 33'd536870912);
        w_sh   = w_left ? (6'd29 - w_msb) : (w_msb - 6'd29);
    end

    assign w_sq  = r_mag[r_idx] * r_mag[r_idx];
    assign w_sum = r_acc + 64'(w_sq);

    always_comb begin
        w_st = r_sres + r_sbit;
        if (r_sv >= w_st) begin
            n_sv   = r_sv - w_st;
            n_sres = (r_sres >> 1) + r_sbit;
        end else begin
            n_sv   = r_sv;
            n_sres = r_sres >> 1;
        end
        w_ph  = (n_sres + 64'd1) >> 1;
        w_piv = (w_ph > 64'(lookq_pkg::ONE_Q30)) ? 31'(lookq_pkg::ONE_Q30) : w_ph[30:0];
    end

    always_comb begin
        m00 = r_r[0];
        m01 = r_r[1];
        m02 = r_r[2];
        m10 = r_u[0];
        m11 = r_u[1];
        m12 = r_u[2];
        m20 = -34'(r_f[0]);
        m21 = -34'(r_f[1]);
        m22 = -34'(r_f[2]);
        w_tr = 36'(m00) + 36'(m11) + 36'(m22);
        if (w_tr > 36'sd0) begin
            w_br = 2'd0;
            w_v  = w_tr + 36'(lookq_pkg::ONE_Q30);
        end else if (m00 > m11 && m00 > m22) begin
            w_br = 2'd1;
            w_v  = 36'(lookq_pkg::ONE_Q30) + 36'(m00) - 36'(m11) - 36'(m22);
        end else if (m11 > m22) begin
            w_br = 2'd2;
            w_v  = 36'(lookq_pkg::ONE_Q30) + 36'(m11) - 36'(m00) - 36'(m22);
        end else begin
            w_br = 2'd3;
            w_v  = 36'(lookq_pkg::ONE_Q30) + 36'(m22) - 36'(m00) - 36'(m11);
        end
    end

    // Numerator of the off-pivot component for the current branch.
    always_comb begin
        w_num = '0;
        case (r_br)
            2'd0: w_num = (r_idx == 2'd0) ? 35'(m21) - 35'(m12) :
                          (r_idx == 2'd1) ? 35'(m02) - 35'(m20) : 35'(m10) - 35'(m01);
            2'd1: w_num = (r_idx == 2'd0) ? 35'(m21) - 35'(m12) :
                          (r_idx == 2'd1) ? 35'(m01) + 35'(m10) : 35'(m02) + 35'(m20);
            2'd2: w_num = (r_idx == 2'd0) ? 35'(m02) - 35'(m20) :
                          (r_idx == 2'd1) ? 35'(m01) + 35'(m10) : 35'(m12) + 35'(m21);
            default: w_num = (r_idx == 2'd0) ? 35'(m10) - 35'(m01) :
                             (r_idx == 2'd1) ? 35'(m02) + 35'(m20) : 35'(m12) + 35'(m21);
        endcase
        w_nabs = w_num[34] ? 35'(-w_num) : 35'(w_num);
    end

    always_comb begin
        if (r_phase == P_Q) begin
            w_den   = {r_piv, 2'b00};
            w_dn    = {w_nabs[33:0], 30'b0} + {32'b0, r_piv, 1'b0};
            w_dneg  = w_num[34];
            w_dzero = (r_piv == '0);
        end else begin
            w_den   = r_sres[32:0];
            w_dn    = {4'b0, r_mag[r_idx], 30'b0} + {32'b0, r_sres[32:1]};
            w_dneg  = r_d[r_idx][32];
            w_dzero = 1'b0;
        end
        w_ge  = (r_rem >= r_dsh);
        w_qm  = (r_sat || r_q > lookq_pkg::ONE_Q30) ? lookq_pkg::ONE_Q30 : r_q;
        w_val = r_neg ? -$signed(w_qm) : $signed(w_qm);
        case (r_phase)
            P_F:     w_last = (r_idx == 2'd2);
            P_C:     w_last = (r_idx == 2'd1);
            default: w_last = (r_idx == 2'd2);
        endcase
    end

    assign w_ma  = r_cnt[0] ? r_c[1] : r_c[0];
    assign w_mb  = (r_cnt[1] == 1'b0) ? r_f[2] : (r_cnt[0] ? r_f[1] : r_f[0]);
    assign w_mul = w_ma * w_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_F;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_d[0] <= i_item.dx;
                        r_d[1] <= i_item.dy;
                        r_d[2] <= i_item.dz;
                        r_vert <= i_item.vert;
                        r_n3   <= 1'b1;
                        r_phase <= P_F;
                        if (i_item.zero) begin
                            r_quat[lookq_pkg::QI_X] <= '0;
                            r_quat[lookq_pkg::QI_Y] <= '0;
                            r_quat[lookq_pkg::QI_Z] <= '0;
                            r_quat[lookq_pkg::QI_W] <= $signed(lookq_pkg::ONE_Q30);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_NSET;
                        end
                    end
                end
                S_NSET: begin
                    r_mag[0] <= shn(w_a0, w_left, w_sh);
                    r_mag[1] <= shn(w_a1, w_left, w_sh);
                    r_mag[2] <= shn(w_a2, w_left, w_sh);
                    r_acc    <= '0;
                    r_idx    <= '0;
                    r_state  <= S_SQ;
                end
                S_SQ: begin
                    if (r_idx == (r_n3 ? 2'd2 : 2'd1)) begin
                        r_sv    <= w_sum;
                        r_sres  <= '0;
                        r_sbit  <= SQ_BIT0;
                        r_cnt   <= '0;
                        r_state <= S_RT;
                    end else begin
                        r_acc <= w_sum;
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_RT: begin
                    r_sv   <= n_sv;
                    r_sres <= n_sres;
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_idx   <= '0;
                        r_state <= S_DVI;
                        if (r_phase == P_PIV) begin
                            r_piv   <= w_piv;
                            r_quat[(r_br == 2'd0) ? lookq_pkg::QI_W : r_br - 2'd1]
                                <= $signed(32'(w_piv));
                            r_phase <= P_Q;
                        end
                    end
                end
                S_DVI: begin
                    r_cnt <= '0;
                    r_q   <= '0;
                    if (w_dzero) begin
                        r_sat   <= 1'b0;
                        r_neg   <= 1'b0;
                        r_state <= S_DVF;
                    end else begin
                        r_rem   <= w_dn;
                        r_dsh   <= {w_den, 31'b0};
                        r_sat   <= ({1'b0, w_dn[63:32]} >= w_den);
                        r_neg   <= w_dneg;
                        r_state <= S_DV;
                    end
                end
                S_DV: begin
                    if (w_ge) r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[30:0], w_ge};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= S_DVF;
                end
                S_DVF: begin
                    case (r_phase)
                        P_F:     r_f[r_idx] <= w_val;
                        P_C:     r_c[r_idx[0]] <= w_val;
                        default: r_quat[qdest(r_br, r_idx)] <= w_val;
                    endcase
                    if (!w_last) begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_DVI;
                    end else begin
                        case (r_phase)
                            P_F: begin
                                if (r_vert) begin
                                    r_r[0]  <= 34'(lookq_pkg::ONE_Q30);
                                    r_r[1]  <= '0;
                                    r_r[2]  <= '0;
                                    r_u[0]  <= '0;
                                    r_u[1]  <= -34'(w_val);
                                    r_u[2]  <= '0;
                                    r_state <= S_TR;
                                end else begin
                                    r_n3    <= 1'b0;
                                    r_phase <= P_C;
                                    r_state <= S_NSET;
                                end
                            end
                            P_C: begin
                                r_r[0]  <= 34'(w_val);
                                r_r[1]  <= -34'(r_c[0]);
                                r_r[2]  <= '0;
                                r_cnt   <= '0;
                                r_state <= S_MUL;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_MUL: begin
                    // c0*f2, c1*f2, c0*f0, c1*f1 in turn; last pair rounded as a sum
                    r_prod <= w_mul;
                    r_cnt  <= r_cnt + 5'd1;
                    case (r_cnt)
                        5'd1: r_u[0] <= -rnd_q30(r_prod);
                        5'd2: r_u[1] <= -rnd_q30(r_prod);
                        5'd3: r_acc  <= r_prod;
                        5'd4: begin
                            r_u[2]  <= rnd_q30($signed(r_acc) + r_prod);
                            r_state <= S_TR;
                        end
                        default: ;
                    endcase
                end
                S_TR: begin
                    r_br  <= w_br;
                    r_idx <= '0;
                    if (w_v <= 36'sd0) begin
                        r_piv   <= '0;
                        r_quat[(w_br == 2'd0) ? lookq_pkg::QI_W : w_br - 2'd1] <= '0;
                        r_phase <= P_Q;
                        r_state <= S_DVI;
                    end else begin
                        r_sv    <= {w_v[33:0], 30'b0};
                        r_sres  <= '0;
                        r_sbit  <= SQ_BIT0;
                        r_cnt   <= '0;
                        r_phase <= P_PIV;
                        r_state <= S_RT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_take   = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_quat_x = r_quat[lookq_pkg::QI_X];
    assign o_quat_y = r_quat[lookq_pkg::QI_Y];
    assign o_quat_z = r_quat[lookq_pkg::QI_Z];
    assign o_quat_w = r_quat[lookq_pkg::QI_W];

endmodule

/* hw/rtl/look_at_quaternion_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Fields
// command   in         start / busy         i_eye_{x,y,z}, i_target_{x,y,z}
// result    out        o_valid (1 cycle)    o_quat_{x,y,z,w}
//
// A word is taken at a clock edge with start high and busy low; it waits in the front
// register, then in a short queue. Busy is high while queue plus front register hold
// QUEUE_DEPTH words. The back end (one root bit and one quotient bit per cycle) skips the
// cross step on a vertical pose, the root when the Shepperd radicand collapses, and all
// steps on eye equal to target. Reset (synchronous, active low) empties the queue.
// Each result shows for exactly one cycle with o_valid; nothing holds it off.

module look_at_quaternion_unit #(
    parameter int QUEUE_DEPTH = lookq_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_eye_x,
    input  logic signed [31:0]  i_eye_y,
    input  logic signed [31:0]  i_eye_z,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    input  logic signed [31:0]  i_target_z,
    output logic                o_valid,
    output logic signed [31:0]  o_quat_x,
    output logic signed [31:0]  o_quat_y,
    output logic signed [31:0]  o_quat_z,
    output logic signed [31:0]  o_quat_w
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic             w_accept;
    logic             w_push;
    lookq_pkg::t_item w_item;
    logic             w_avail;
    lookq_pkg::t_item w_head;
    logic [CW-1:0]    w_count;
    logic             w_take;

    // Hold busy while the queue plus the word in the front register fill it.
    assign busy     = ((CW + 1)'(w_count) + (CW + 1)'(w_push)) >= (CW + 1)'(QUEUE_DEPTH);
    assign w_accept = start && !busy;

    lookq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_eye_x    (i_eye_x),
        .i_eye_y    (i_eye_y),
        .i_eye_z    (i_eye_z),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_target_z (i_target_z),
        .o_push     (w_push),
        .o_item     (w_item)
    );

    lookq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_take),
        .o_avail (w_avail),
        .o_head  (w_head),
        .o_count (w_count)
    );

    // Advance one word at a time through normalize, cross, Shepperd.
    lookq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (w_avail),
        .i_item   (w_head),
        .o_take   (w_take),
        .o_valid  (o_valid),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z),
        .o_quat_w (o_quat_w)
    );

`ifndef SYNTHESIS
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(w_count) == QUEUE_DEPTH) |-> busy)
        else $error("queue full without busy");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat_w <= 32'sd1073741824 && o_quat_w >= -32'sd1073741824))
        else $error("w component out of Q1.30 range");
`endif

endmodule
